@@ sv/iirl_pkg.sv @@
package iirl_pkg;

   localparam int DEPTH      = 64;
   localparam int WORD_WIDTH = 32;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 7;
   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;
   localparam int CMP_W = CNT_W + POS_W;

   localparam int REQ_DATA_W = ((POS_W + WORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((WORD_WIDTH + CNT_W + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_WRITE
   } cell_op_type;

   typedef struct packed {
      cell_op_type           op;
      logic [IDX_W-1:0]      idx;
      logic [WORD_WIDTH-1:0] word;
   } cell_ctrl_type;

endpackage

@@ sv/iirl_cell.sv @@
module iirl_cell
   import iirl_pkg::*;
(
   input  logic                  clock,
   input  logic [IDX_W-1:0]      cell_index,
   input  cell_ctrl_type         ctrl,
   input  logic [WORD_WIDTH-1:0] left_word,
   input  logic [WORD_WIDTH-1:0] right_word,
   output logic [WORD_WIDTH-1:0] word
);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (cell_index > ctrl.idx) begin
               word_in = left_word;
            end else if (cell_index == ctrl.idx) begin
               word_in = ctrl.word;
            end
         end
         CELL_REMOVE: begin
            if (cell_index >= ctrl.idx) begin
               word_in = right_word;
            end
         end
         CELL_WRITE: begin
            if (cell_index == ctrl.idx) begin
               word_in = ctrl.word;
            end
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ sv/indexed_insert_remove_list_core.sv @@
// Ordered list of words with insert, remove, get and set at an index.
// Requests enter on the req_ stream: req_tuser carries the operation,
// req_tdata the position (7-bit signed, -1 = end of list) and the word.
// Each request yields exactly one item on the rsp_ stream: the word read
// by a get (zero otherwise), the entry count afterwards and a status
// (ok, list full on insert, index out of range).
// Storage is a row of cells, one word each. An insert or remove shifts
// the cells from the index onward by one place in the same cycle, so a
// request is done in the cycle it is accepted and its result is valid on
// the next cycle. Throughput is one request per cycle while results are taken.
// A single output register holds the result. req_tready is high while
// that register is empty or being taken, so when the receiver stalls the
// block takes no further request until the waiting item is accepted.
// Reset clears the entry count and the output valid flag; the stored words
// are not cleared and are only read after being written.
module indexed_insert_remove_list_core
   import iirl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // position, word_in, zero padding
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // word_out, count_now, zero padding
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [STAT_W-1:0]     rsp_tuser
);

   logic [WORD_WIDTH-1:0] cell_word [DEPTH];
   cell_ctrl_type         ctrl;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] word_out_ff, word_out_in;
   logic [STAT_W-1:0]     status_ff, status_in;

   logic                  accept;
   logic [FUNC_W-1:0]     func;
   logic [POS_W-1:0]      position;
   logic [WORD_WIDTH-1:0] word_in;
   logic                  at_end, neg;
   logic [CMP_W-1:0]      count_ext, idx;

   assign func     = req_tuser;
   assign position = req_tdata[POS_W-1:0];
   assign word_in  = req_tdata[POS_W +: WORD_WIDTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign at_end    = &position;
   assign neg       = position[POS_W-1] && !at_end;
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      idx = CMP_W'(position[POS_W-2:0]);
      if (at_end) begin
         idx = (func == FUNC_INSERT) ? count_ext : count_ext - CMP_W'(1);
      end
   end

   always_comb begin
      status_in    = STATUS_OK;
      word_out_in  = '0;
      count_in     = count_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.idx     = idx[IDX_W-1:0];
      ctrl.word    = word_in;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (func == FUNC_INSERT) begin
            if (neg || idx > count_ext) begin
               status_in = STATUS_RANGE;
            end else if (count_ff >= CNT_W'(DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.op  = CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end else if (neg || (at_end && count_ff == '0) || idx >= count_ext) begin
            status_in = STATUS_RANGE;
         end else begin
            case (func)
               FUNC_REMOVE: begin
                  ctrl.op  = CELL_REMOVE;
                  count_in = count_ff - CNT_W'(1);
               end
               FUNC_GET: word_out_in = cell_word[idx[IDX_W-1:0]];
               FUNC_SET: ctrl.op = CELL_WRITE;
               default:  ctrl.op = CELL_HOLD;
            endcase
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word, right_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = cell_word[i+1];
      end
      iirl_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctrl       (ctrl),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         word_out_ff <= word_out_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({count_ff, word_out_ff});
   assign rsp_tuser  = status_ff;

endmodule

@@ sv/iirl_checker.sv @@
module iirl_checker
   import iirl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STAT_W-1:0]     rsp_tuser
);

   // stalled item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item dropped or changed while stalled");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output register");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL
         |-> rsp_tdata[WORD_WIDTH +: CNT_W] == CNT_W'(DEPTH))
      else $error("full status with list not full");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[WORD_WIDTH-1:0] == '0)
      else $error("failed request returned a word");

endmodule

bind indexed_insert_remove_list_core iirl_checker u_checker (.*);

@@ verif/indexed_insert_remove_list_core_tb.sv @@
module indexed_insert_remove_list_core_tb;
   import iirl_pkg::*;

   localparam logic [POS_W-1:0] END_POS = 7'h7F;
   localparam int N_DIRECTED = 25;
   localparam int RAND_ITEMS = 1100;
   localparam int PHASE_LEN = 110;
   localparam int QUIET_TAIL = 150;
   localparam int LONG_HOLD = 40;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] word;
      logic [CNT_W-1:0]      count;
      logic [STAT_W-1:0]     status;
   } list_result_type;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [POS_W-1:0]      pos;
      logic [WORD_WIDTH-1:0] word;
      bit                    typed;
      list_result_type       want;
   } stim_row_type;

   typedef enum {MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_NOISE} mix_mode_type;

   localparam list_result_type UNTYPED = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = FUNC_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   logic [WORD_WIDTH-1:0] shadow_words [DEPTH];
   int                    shadow_len = 0;
   list_result_type       pending_results [$];
   int                    error_count = 0;
   int                    items_sent = 0;
   int                    items_checked = 0;
   int                    status_seen [3] = '{0, 0, 0};
   int                    peak_len = 0;
   bit                    quiet = 1'b0;
   bit                    long_hold_req = 1'b0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{FUNC_GET,    END_POS,  32'h1234_5678, 1'b1, '{32'h0, 7'd0, STATUS_RANGE}},
      '{FUNC_REMOVE, 7'd0,     32'h0,         1'b1, '{32'h0, 7'd0, STATUS_RANGE}},
      '{FUNC_SET,    END_POS,  32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd0, STATUS_RANGE}},
      '{FUNC_INSERT, 7'd1,     32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd0, STATUS_RANGE}},
      '{FUNC_INSERT, 7'h7E,    32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd0, STATUS_RANGE}},
      '{FUNC_INSERT, 7'h40,    32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd0, STATUS_RANGE}},
      '{FUNC_INSERT, END_POS,  32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd1, STATUS_OK}},
      '{FUNC_INSERT, 7'd0,     32'h0,         1'b1, '{32'h0, 7'd2, STATUS_OK}},
      '{FUNC_GET,    7'd0,     32'hDEAD_BEEF, 1'b1, '{32'h0, 7'd2, STATUS_OK}},
      '{FUNC_GET,    7'd1,     32'h0,         1'b1, '{32'hFFFF_FFFF, 7'd2, STATUS_OK}},
      '{FUNC_GET,    END_POS,  32'h0,         1'b1, '{32'hFFFF_FFFF, 7'd2, STATUS_OK}},
      '{FUNC_GET,    7'd2,     32'h0,         1'b1, '{32'h0, 7'd2, STATUS_RANGE}},
      '{FUNC_GET,    7'd63,    32'h0,         1'b1, '{32'h0, 7'd2, STATUS_RANGE}},
      '{FUNC_INSERT, 7'd1,     32'hA5A5_A5A5, 1'b0, UNTYPED},
      '{FUNC_GET,    7'd1,     32'h0,         1'b0, UNTYPED},
      '{FUNC_GET,    7'd2,     32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{FUNC_SET,    7'd0,     32'h5A5A_5A5A, 1'b0, UNTYPED},
      '{FUNC_SET,    END_POS,  32'h8000_0001, 1'b0, UNTYPED},
      '{FUNC_GET,    7'd0,     32'h0,         1'b0, UNTYPED},
      '{FUNC_GET,    END_POS,  32'h0,         1'b0, UNTYPED},
      '{FUNC_REMOVE, 7'd1,     32'h0,         1'b0, UNTYPED},
      '{FUNC_GET,    7'd1,     32'h0,         1'b0, UNTYPED},
      '{FUNC_REMOVE, END_POS,  32'h0,         1'b0, UNTYPED},
      '{FUNC_REMOVE, 7'd0,     32'h0,         1'b0, UNTYPED},
      '{FUNC_REMOVE, 7'd0,     32'h0,         1'b1, '{32'h0, 7'd0, STATUS_RANGE}}
   };

   indexed_insert_remove_list_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic list_result_type list_step(input logic [FUNC_W-1:0] f,
                                                 input logic [POS_W-1:0] p,
                                                 input logic [WORD_WIDTH-1:0] w);
      list_result_type r;
      int idx;
      bit at_end;
      bit neg;
      r = '0;
      r.status = STATUS_OK;
      idx = 0;
      at_end = (p == END_POS);
      neg = p[POS_W-1] && !at_end;
      if (f == FUNC_INSERT) begin
         if (neg) begin
            r.status = STATUS_RANGE;
         end else begin
            idx = at_end ? shadow_len : int'(p);
            if (idx > shadow_len) r.status = STATUS_RANGE;
            else if (shadow_len >= DEPTH) r.status = STATUS_FULL;
         end
         if (r.status == STATUS_OK) begin
            for (int i = shadow_len; i > idx; i--) shadow_words[i] = shadow_words[i-1];
            shadow_words[idx] = w;
            shadow_len++;
         end
      end else begin
         if (neg || (at_end && shadow_len == 0)) begin
            r.status = STATUS_RANGE;
         end else begin
            idx = at_end ? shadow_len - 1 : int'(p);
            if (idx >= shadow_len) r.status = STATUS_RANGE;
         end
         if (r.status == STATUS_OK) begin
            case (f)
               FUNC_REMOVE: begin
                  for (int i = idx; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
                  shadow_len--;
               end
               FUNC_GET: r.word = shadow_words[idx];
               default: shadow_words[idx] = w;
            endcase
         end
      end
      r.count = shadow_len[CNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < 20)
         $display("mismatch on %s at result %0d: got %0h, want %0h",
                  field, items_checked, got, want);
      error_count++;
   endtask

   task automatic push_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                               input logic [WORD_WIDTH-1:0] w, input bit typed,
                               input list_result_type typed_res);
      list_result_type pred;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {{(REQ_DATA_W-POS_W-WORD_WIDTH){1'b0}}, w, p};
      do @(posedge clock); while (!req_tready);
      pred = list_step(f, p, w);
      pending_results.push_back(typed ? typed_res : pred);
      items_sent++;
      status_seen[pred.status]++;
      if (shadow_len > peak_len) peak_len = shadow_len;
   endtask

   task automatic check_result();
      list_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected item", 64'({rsp_tuser, rsp_tdata}), 64'h0);
         return;
      end
      want = pending_results.pop_front();
      if (rsp_tdata[WORD_WIDTH-1:0] !== want.word)
         report_mismatch("word_out", 64'(rsp_tdata[WORD_WIDTH-1:0]), 64'(want.word));
      if (rsp_tdata[WORD_WIDTH +: CNT_W] !== want.count)
         report_mismatch("count_now", 64'(rsp_tdata[WORD_WIDTH +: CNT_W]), 64'(want.count));
      if (rsp_tuser !== want.status)
         report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
      items_checked++;
   endtask

   // receiver: random stall bursts, one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) check_result();
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      mix_mode_type mode;
      logic [FUNC_W-1:0] f;
      logic [POS_W-1:0] p;
      int roll;
      int wild_pct;
      int bound;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k])
         push_request(directed_rows[k].func, directed_rows[k].pos, directed_rows[k].word,
                      directed_rows[k].typed, directed_rows[k].want);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
         if (n == 300) long_hold_req = 1'b1;
         if (n == 600) begin
            // let the list settle with nothing in flight
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         case ((n / PHASE_LEN) % 4)
            0: mode = MODE_FILL;
            1: mode = MODE_MIXED;
            2: mode = MODE_DRAIN;
            default: mode = MODE_NOISE;
         endcase
         roll = $urandom_range(0, 99);
         case (mode)
            MODE_FILL:  f = roll < 70 ? FUNC_INSERT : roll < 80 ? FUNC_REMOVE :
                            roll < 90 ? FUNC_GET : FUNC_SET;
            MODE_DRAIN: f = roll < 10 ? FUNC_INSERT : roll < 75 ? FUNC_REMOVE :
                            roll < 88 ? FUNC_GET : FUNC_SET;
            default:    f = roll < 30 ? FUNC_INSERT : roll < 55 ? FUNC_REMOVE :
                            roll < 80 ? FUNC_GET : FUNC_SET;
         endcase
         wild_pct = (mode == MODE_NOISE) ? 50 : 10;
         roll = $urandom_range(0, 99);
         if (roll < wild_pct) begin
            p = POS_W'($urandom_range(0, 127));
         end else if (roll < wild_pct + 10) begin
            p = END_POS;
         end else begin
            bound = (f == FUNC_INSERT) ? shadow_len : (shadow_len == 0 ? 0 : shadow_len - 1);
            p = POS_W'($urandom_range(0, bound));
         end
         push_request(f, p, $urandom(), 1'b0, UNTYPED);
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("%0d requests sent, %0d results checked; peak list length %0d",
               items_sent, items_checked, peak_len);
      $display("status counts: ok %0d, full %0d, out of range %0d",
               status_seen[0], status_seen[1], status_seen[2]);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #800000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ indexed_insert_remove_list_core.f @@
sv/iirl_pkg.sv
sv/iirl_cell.sv
sv/indexed_insert_remove_list_core.sv
sv/iirl_checker.sv
verif/indexed_insert_remove_list_core_tb.sv
